@@ design/spq_pkg.sv @@
package spq_pkg;

  localparam int unsigned DefaultQueueDepth = 16;
  localparam int unsigned ValueWidth        = 32;
  localparam int unsigned CountWidth        = 5;
  localparam int unsigned OpWidth           = 2;

  localparam logic [OpWidth-1:0] OpInsert = 2'd0;
  localparam logic [OpWidth-1:0] OpRemove = 2'd1;
  localparam logic [OpWidth-1:0] OpFind   = 2'd2;

  typedef struct packed {
    logic [CountWidth-1:0]        entry_count;
    logic signed [ValueWidth-1:0] head_value;
    logic                         head_valid;
    logic                         overflow;
    logic                         success;
  } spq_res_t;

endpackage

@@ design/spq_ram.sv @@
module spq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/spq_ctrl.sv @@
module spq_ctrl import spq_pkg::*; #(
  parameter int unsigned QueueDepth = DefaultQueueDepth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [OpWidth-1:0]               opcode_i,
  input  logic signed [ValueWidth-1:0]     operand_i,
  output logic                             ram_we_o,
  output logic [$clog2(QueueDepth)-1:0]    ram_waddr_o,
  output logic [ValueWidth-1:0]            ram_wdata_o,
  output logic                             ram_re_o,
  output logic [$clog2(QueueDepth)-1:0]    ram_raddr_o,
  input  logic [ValueWidth-1:0]            ram_rdata_i,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output spq_res_t                         res_o
);

  localparam int unsigned AddrWidth = $clog2(QueueDepth);
  localparam int unsigned CntWidth  = $clog2(QueueDepth + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StEval = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [OpWidth-1:0]           op_q, op_d;
  logic signed [ValueWidth-1:0] val_q, val_d;
  logic [CntWidth-1:0]          pos_q, pos_d;
  logic [CntWidth-1:0]          occ_q, occ_d;
  logic                         shift_q, shift_d;
  logic                         success_q, success_d;
  logic                         overflow_q, overflow_d;
  logic signed [ValueWidth-1:0] head_q;
  logic [CntWidth-1:0]          pos_dec;
  logic [CntWidth-1:0]          pos_inc;
  logic                         full;

  assign pos_dec = pos_q - CntWidth'(1);
  assign pos_inc = pos_q + CntWidth'(1);
  assign full    = (occ_q == CntWidth'(QueueDepth));

  assign in_ready_o  = (state_q == StIdle);
  assign res_valid_o = (state_q == StFin);

  always_comb begin
    res_o.success     = success_q;
    res_o.overflow    = overflow_q;
    res_o.head_valid  = (occ_q != '0);
    res_o.head_value  = (occ_q != '0) ? head_q : '0;
    res_o.entry_count = CountWidth'(occ_q);
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    val_d       = val_q;
    pos_d       = pos_q;
    occ_d       = occ_q;
    shift_d     = shift_q;
    success_d   = success_q;
    overflow_d  = overflow_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = pos_q[AddrWidth-1:0];
    ram_wdata_o = val_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = pos_q[AddrWidth-1:0];

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          op_d       = opcode_i;
          val_d      = operand_i;
          shift_d    = 1'b0;
          success_d  = 1'b0;
          overflow_d = 1'b0;
          case (opcode_i) inside
            OpInsert: begin
              if (full) begin
                overflow_d = 1'b1;
                state_d    = StFin;
              end else begin
                pos_d   = occ_q;
                state_d = StRead;
              end
            end
            OpRemove, OpFind: begin
              pos_d   = '0;
              state_d = StRead;
            end
            default: state_d = StFin;
          endcase
        end
      end

      StRead: begin
        if (op_q == OpInsert) begin
          // pos is the free slot; compare against the entry just above it
          if (pos_q == '0) begin
            ram_we_o    = 1'b1;
            ram_waddr_o = '0;
            ram_wdata_o = val_q;
            occ_d       = occ_q + CntWidth'(1);
            success_d   = 1'b1;
            state_d     = StFin;
          end else begin
            ram_re_o    = 1'b1;
            ram_raddr_o = pos_dec[AddrWidth-1:0];
            state_d     = StEval;
          end
        end else if (pos_q == occ_q) begin
          if (shift_q) begin
            occ_d     = occ_q - CntWidth'(1);
            success_d = 1'b1;
          end
          state_d = StFin;
        end else begin
          ram_re_o = 1'b1;
          state_d  = StEval;
        end
      end

      StEval: begin
        if (op_q == OpInsert) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = pos_q[AddrWidth-1:0];
          if ($signed(ram_rdata_i) < val_q) begin
            ram_wdata_o = ram_rdata_i;
            pos_d       = pos_dec;
            state_d     = StRead;
          end else begin
            ram_wdata_o = val_q;
            occ_d       = occ_q + CntWidth'(1);
            success_d   = 1'b1;
            state_d     = StFin;
          end
        end else if (shift_q) begin
          // close the gap left by the removed entry
          ram_we_o    = 1'b1;
          ram_waddr_o = pos_dec[AddrWidth-1:0];
          ram_wdata_o = ram_rdata_i;
          pos_d       = pos_inc;
          state_d     = StRead;
        end else if ($signed(ram_rdata_i) == val_q) begin
          if (op_q == OpFind) begin
            success_d = 1'b1;
            state_d   = StFin;
          end else begin
            shift_d = 1'b1;
            pos_d   = pos_inc;
            state_d = StRead;
          end
        end else begin
          pos_d   = pos_inc;
          state_d = StRead;
        end
      end

      StFin: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      occ_q   <= '0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    val_q      <= val_d;
    pos_q      <= pos_d;
    shift_q    <= shift_d;
    success_q  <= success_d;
    overflow_q <= overflow_d;
    // shadow copy of entry 0
    if (ram_we_o && ram_waddr_o == '0) begin
      head_q <= ram_wdata_o;
    end
  end

endmodule

@@ design/sorted_priority_queue.sv @@
// channel  dir  tdata fields (lsb first)                                   bits
// s_axis   in   opcode[1:0], operand_value[33:2], zero pad                   40
// m_axis   out  success[0], overflow[1], head_valid[2], head_value[34:3],
//               entry_count[39:35]                                           40
//
// one item at a time; entries live in a single ram with a registered read
// insert moves each smaller entry down by one slot in a read-compare-write
// loop until the value finds its place; remove scans from the head, then
// shifts the later entries up to close the gap; find scans from the head;
// full inserts and unused opcodes go straight to the result
// reset clears the control state and the entry count only, no ram clearing pass is needed
// a result waiting in the output register does not block the next transfer
module sorted_priority_queue import spq_pkg::*; #(
  parameter int unsigned QueueDepth = DefaultQueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // opcode, operand_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // success, overflow, head_valid, head_value, entry_count
);

  localparam int unsigned AddrWidth = $clog2(QueueDepth);

  logic                  ram_we;
  logic [AddrWidth-1:0]  ram_waddr;
  logic [ValueWidth-1:0] ram_wdata;
  logic                  ram_re;
  logic [AddrWidth-1:0]  ram_raddr;
  logic [ValueWidth-1:0] ram_rdata;
  logic                  res_valid;
  logic                  res_ready;
  spq_res_t              res;
  logic                  out_valid_q;
  spq_res_t              out_q;

  spq_ram #(
    .Width (ValueWidth),
    .Depth (QueueDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  spq_ctrl #(
    .QueueDepth (QueueDepth)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .opcode_i    (s_axis_tdata[1:0]),
    .operand_i   (s_axis_tdata[33:2]),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.entry_count, out_q.head_value, out_q.head_valid,
                          out_q.overflow, out_q.success};

endmodule
